// ===== rtl/core/wwcf_pkg.sv =====
// Shared types and constants for the whole-word censor filter core.
// Used by wwcf_cell and whole_word_censor_filter_core; depends on nothing.
`default_nettype none

package wwcf_pkg;

  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 5;
  localparam int CFG_W          = 64;
  localparam int CFG_IDX_W      = 2;
  // Number of word characters the configuration registers can hold.
  localparam int WORD_CAP       = 24;
  localparam int WORD_LIMIT_DEF = 24;

  localparam logic [CHAR_W-1:0] DELIM_CHAR = 8'd32;
  localparam logic [CHAR_W-1:0] MASK_CHAR  = 8'd120;

  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_MID  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_HIGH = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN  = 2'd3;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              text_end;
  } wwcf_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              run_last;
    logic              text_done;
  } wwcf_out_t;

  // Per-cell control: load the incoming byte, or take the neighbor's byte.
  typedef struct packed {
    logic load;
    logic shift;
  } wwcf_cell_ctl_t;

endpackage : wwcf_pkg

`default_nettype wire

// ===== rtl/core/wwcf_cell.sv =====
// One cell of the token buffer chain: holds one byte of the current token.
// Depends on wwcf_pkg for the character width and the cell control struct.
`default_nettype none

module wwcf_cell (
  input  wire                          clk,
  input  wwcf_pkg::wwcf_cell_ctl_t     ctl,
  input  wire [wwcf_pkg::CHAR_W-1:0]   load_char,
  input  wire [wwcf_pkg::CHAR_W-1:0]   next_char,
  output logic [wwcf_pkg::CHAR_W-1:0]  char_q
);
  import wwcf_pkg::*;

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;

  always_comb begin
    char_nxt = char_r;
    if (ctl.load) begin
      char_nxt = load_char;
    end else if (ctl.shift) begin
      char_nxt = next_char;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;

endmodule : wwcf_cell

`default_nettype wire

// ===== rtl/core/whole_word_censor_filter_core.sv =====
// Whole-word censor filter: tokens held in a chain of byte cells, censored on exact match.
// A lone result goes straight into the output register; a flush of buffered bytes first
// enters the flush state, then sends each byte through the output register.
// One byte per cycle when the output does not stall and each byte causes at most one result;
// a flush holds input until its N bytes and any trailing delimiter or byte have been sent.
// Reset (rst_n low, synchronous): state, counts, valids and configuration clear; cells keep data.
`default_nettype none

module whole_word_censor_filter_core #(
  parameter int WORD_LIMIT = wwcf_pkg::WORD_LIMIT_DEF
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wwcf_pkg::wwcf_in_t              in_data,
  output logic                            out_valid,
  input  wire                             out_stall,
  output wwcf_pkg::wwcf_out_t             out_data,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire [wwcf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [wwcf_pkg::CFG_W-1:0]       cfg_data
);
  import wwcf_pkg::*;

  localparam int CNT_W = $clog2(WORD_LIMIT + 1);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_FLUSH = 1'b1;

  // Configuration registers.
  logic [CFG_W-1:0] word_low_r, word_mid_r, word_high_r;
  logic [LEN_W-1:0] word_len_r;
  logic [3*CFG_W-1:0] word_flat;

  // Token and sequencing state.
  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             match_r, match_nxt;
  logic             pass_r, pass_nxt;
  logic [CNT_W-1:0] flush_left_r, flush_left_nxt;
  logic             mask_r, mask_nxt;
  logic             tail_valid_r, tail_valid_nxt;
  logic [CHAR_W-1:0] tail_char_r, tail_char_nxt;
  logic             end_r, end_nxt;
  logic             out_valid_r, out_valid_nxt;
  wwcf_out_t        out_data_r, out_data_nxt;

  wwcf_cell_ctl_t   cell_ctl [WORD_LIMIT];
  logic [CHAR_W-1:0] cell_char [WORD_LIMIT];

  logic             in_fire, slot_free, is_space, is_last;
  logic             store_byte, shift_chain;
  logic [LEN_W-1:0] limit;
  logic             wl_ok, hit_space, hit_store, match_store;
  logic [CNT_W-1:0] count_inc;
  logic [CHAR_W-1:0] word_char;
  logic [CNT_W-1:0] nflush;
  logic             ntail, nmask;
  logic [CHAR_W-1:0] ntail_char;
  logic             emit_last;

  assign cfg_ready = 1'b1;
  assign word_flat = {word_high_r, word_mid_r, word_low_r};

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign is_space  = (in_data.in_char == DELIM_CHAR);
  assign is_last   = in_data.text_end;

  assign limit = (word_len_r <= LEN_W'(WORD_LIMIT)) ? word_len_r : LEN_W'(WORD_LIMIT);
  assign wl_ok = (word_len_r != '0) && (word_len_r <= LEN_W'(WORD_LIMIT));
  assign count_inc = count_r + 1'b1;

  // Word character at the position the next stored byte will take.
  always_comb begin
    word_char = '0;
    for (int i = 0; i < WORD_LIMIT; i++) begin
      if (count_r == CNT_W'(i)) begin
        word_char = word_flat[CHAR_W*i +: CHAR_W];
      end
    end
  end

  assign store_byte  = in_fire && !is_space && !pass_r && (LEN_W'(count_r) < limit);
  assign match_store = match_r && (in_data.in_char == word_char);
  assign hit_space   = match_r && wl_ok && (LEN_W'(count_r) == word_len_r);
  assign hit_store   = match_store && wl_ok && (LEN_W'(count_inc) == word_len_r);

  // What one accepted byte produces: N buffered bytes, then an optional tail byte.
  always_comb begin
    nflush     = '0;
    nmask      = 1'b0;
    ntail      = 1'b0;
    ntail_char = in_data.in_char;
    if (is_space) begin
      nflush = pass_r ? '0 : count_r;
      nmask  = hit_space && !pass_r;
      ntail  = 1'b1;
    end else if (pass_r) begin
      ntail = 1'b1;
    end else if (LEN_W'(count_r) >= limit) begin
      nflush = count_r;
      ntail  = 1'b1;
    end else if (is_last) begin
      nflush = count_inc;
      nmask  = hit_store;
    end
  end

  assign emit_last   = (flush_left_r == CNT_W'(1)) && !tail_valid_r;
  assign shift_chain = (state_r == ST_FLUSH) && slot_free && (flush_left_r != '0);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    match_nxt      = match_r;
    pass_nxt       = pass_r;
    flush_left_nxt = flush_left_r;
    mask_nxt       = mask_r;
    tail_valid_nxt = tail_valid_r;
    tail_char_nxt  = tail_char_r;
    end_nxt        = end_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (is_space) begin
            count_nxt = '0;
            match_nxt = 1'b1;
            pass_nxt  = 1'b0;
          end else if (pass_r) begin
            count_nxt = count_r;
          end else if (LEN_W'(count_r) >= limit) begin
            pass_nxt  = 1'b1;
            match_nxt = 1'b0;
          end else begin
            count_nxt = count_inc;
            match_nxt = match_store;
          end
          if (is_last) begin
            count_nxt = '0;
            match_nxt = 1'b1;
            pass_nxt  = 1'b0;
          end

          if (nflush != '0) begin
            state_nxt      = ST_FLUSH;
            flush_left_nxt = nflush;
            mask_nxt       = nmask;
            tail_valid_nxt = ntail;
            tail_char_nxt  = ntail_char;
            end_nxt        = is_last;
          end else if (ntail) begin
            // Nothing buffered: the byte goes straight to the output register.
            out_valid_nxt          = 1'b1;
            out_data_nxt.out_char  = ntail_char;
            out_data_nxt.run_last  = 1'b1;
            out_data_nxt.text_done = is_last;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (flush_left_r != '0) begin
            out_data_nxt.out_char  = mask_r ? MASK_CHAR : cell_char[0];
            out_data_nxt.run_last  = emit_last;
            out_data_nxt.text_done = emit_last && end_r;
            flush_left_nxt         = flush_left_r - 1'b1;
            if (emit_last) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            out_data_nxt.out_char  = tail_char_r;
            out_data_nxt.run_last  = 1'b1;
            out_data_nxt.text_done = end_r;
            tail_valid_nxt         = 1'b0;
            state_nxt              = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      match_r      <= 1'b1;
      pass_r       <= 1'b0;
      flush_left_r <= '0;
      tail_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      match_r      <= match_nxt;
      pass_r       <= pass_nxt;
      flush_left_r <= flush_left_nxt;
      tail_valid_r <= tail_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mask_r      <= mask_nxt;
    tail_char_r <= tail_char_nxt;
    end_r       <= end_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_low_r  <= '0;
      word_mid_r  <= '0;
      word_high_r <= '0;
      word_len_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WORD_LOW:  word_low_r  <= cfg_data;
        CFG_WORD_MID:  word_mid_r  <= cfg_data;
        CFG_WORD_HIGH: word_high_r <= cfg_data;
        CFG_WORD_LEN:  word_len_r  <= cfg_data[LEN_W-1:0];
      endcase
    end
  end

  // Token buffer: cell i is loaded when the token reaches position i; during a flush
  // every cell but the last takes its neighbor's byte so cell 0 always holds the next one.
  for (genvar g = 0; g < WORD_LIMIT; g++) begin : g_cell
    assign cell_ctl[g].load  = store_byte && (count_r == CNT_W'(g));
    assign cell_ctl[g].shift = shift_chain;
    if (g == WORD_LIMIT - 1) begin : g_end
      wwcf_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[g]),
        .load_char (in_data.in_char),
        .next_char (cell_char[g]),
        .char_q    (cell_char[g])
      );
    end else begin : g_mid
      wwcf_cell u_cell (
        .clk       (clk),
        .ctl       (cell_ctl[g]),
        .load_char (in_data.in_char),
        .next_char (cell_char[g+1]),
        .char_q    (cell_char[g])
      );
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WORD_LIMIT))
    else $error("token count beyond the cell chain");

  a_pass_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r |-> !match_r)
    else $error("pass-through token still marked as matching");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.text_done |-> out_data_r.run_last)
    else $error("text end flagged on a result that is not the last of its byte");

  a_flush_state: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_left_r != '0) |-> (state_r == ST_FLUSH))
    else $error("buffered bytes pending outside the flush state");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result lost or changed");

endmodule : whole_word_censor_filter_core

`default_nettype wire
